@@ design/crc_long_division_bitserial_macros.svh @@
// Assertion macros for the CRC long-division top-level design file.
// No dependencies; included by files that carry concurrent checks.
`ifndef CRC_LONG_DIVISION_BITSERIAL_MACROS_SVH
`define CRC_LONG_DIVISION_BITSERIAL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRCLD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crcld check failed");

// Next-cycle implication, disabled during reset.
`define CRCLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crcld check failed");

`endif

@@ design/crcld_pkg.sv @@
// Shared types and constants for the bit-serial CRC long divider.
// No dependencies; used by crcld_core and crc_long_division_bitserial.
package crcld_pkg;

  // Width of the divisor length register.
  localparam int LEN_W = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;

  // Result kinds carried on tuser.
  localparam logic KIND_QUOT = 1'b0;
  localparam logic KIND_REM  = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_REM
  } state_t;

  // Control from the sequencer to the division core.
  typedef struct packed {
    logic step;    // shift one dividend bit in
    logic bit_in;  // the bit shifted in
    logic clear;   // end of message: drop remainder and window count
  } step_ctl_t;

  // Status from the core for the current step.
  typedef struct packed {
    logic emit;    // this step yields a quotient bit
    logic qbit;    // the quotient bit
  } step_stat_t;

endpackage

@@ design/crc_long_division_bitserial.sv @@
// Bit-serial CRC long divider: modulo-2 division of a dividend stream by a
// configurable divisor of up to MAX_DIVISOR_BITS bits. Dividend bits enter
// one per input transaction, most significant first, tlast on the last bit.
// Once the first n-bit window has filled, every bit yields one quotient-bit
// result (tuser = 0). After the last bit the block shifts in n-1 zeros on
// its own (n = clamped divisor length), one per cycle while the output
// drains, emitting their quotient bits, then sends the n-1 bit remainder
// (tuser = 1, tlast = 1) and clears for the next message. Rate: one
// dividend bit per cycle while the output drains; during the zero flush and
// the remainder step s_tready is low. The per-cycle work is a single
// shift-and-XOR of the remainder register in crcld_core.
// Depends on crcld_pkg, crcld_core and the macros header.
`include "crc_long_division_bitserial_macros.svh"

module crc_long_division_bitserial #(
  parameter int MAX_DIVISOR_BITS = 33,
  localparam int PR_W    = MAX_DIVISOR_BITS - 1,
  localparam int CNT_W   = $clog2(MAX_DIVISOR_BITS),
  localparam int TDATA_W = ((MAX_DIVISOR_BITS + 7) / 8) * 8,
  localparam int CFG_W   = (MAX_DIVISOR_BITS > crcld_pkg::LEN_W) ?
                           MAX_DIVISOR_BITS : crcld_pkg::LEN_W
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crcld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  // dividend stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [0] data_bit, rest zero
  input  logic                            s_tlast,  // final_bit
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [TDATA_W-1:0]              m_tdata,  // [0] quotient_bit, then remainder
  output logic                            m_tuser,  // kind
  output logic                            m_tlast   // end_of_run
);

  // configuration registers
  logic [MAX_DIVISOR_BITS-1:0]     div_pattern;
  logic [crcld_pkg::LEN_W-1:0]     div_length;
  logic [crcld_pkg::LEN_W-1:0]     eff_len;
  logic [CNT_W-1:0]                rb;

  crcld_pkg::state_t               state, state_next;
  logic [CNT_W-1:0]                flush_left, flush_left_next;
  crcld_pkg::step_ctl_t            ctl;
  crcld_pkg::step_stat_t           stat;
  logic [PR_W-1:0]                 core_rem;
  logic                            load_rem;
  logic                            adv;

  // output register
  logic                            out_valid;
  logic                            out_kind;
  logic                            out_q;
  logic [PR_W-1:0]                 out_rem;
  logic                            out_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pattern <= MAX_DIVISOR_BITS'(7);
      div_length  <= crcld_pkg::LEN_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == crcld_pkg::REG_PATTERN) begin
        div_pattern <= cfg_data[MAX_DIVISOR_BITS-1:0];
      end else if (cfg_index == crcld_pkg::REG_LENGTH) begin
        div_length <= cfg_data[crcld_pkg::LEN_W-1:0];
      end
    end
  end

  // length clamps to [2, MAX_DIVISOR_BITS]
  always_comb begin
    if (div_length < crcld_pkg::LEN_W'(2)) begin
      eff_len = crcld_pkg::LEN_W'(2);
    end else if (div_length > crcld_pkg::LEN_W'(MAX_DIVISOR_BITS)) begin
      eff_len = crcld_pkg::LEN_W'(MAX_DIVISOR_BITS);
    end else begin
      eff_len = div_length;
    end
    rb = CNT_W'(eff_len - crcld_pkg::LEN_W'(1));
  end

  crcld_core #(
    .MAX_DIVISOR_BITS(MAX_DIVISOR_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .pattern   (div_pattern),
    .rb        (rb),
    .stat      (stat),
    .remainder (core_rem)
  );

  // a step may run only when the output slot is free or draining
  assign adv = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= crcld_pkg::ST_RUN;
      flush_left <= '0;
    end else begin
      state      <= state_next;
      flush_left <= flush_left_next;
    end
  end

  always_comb begin
    state_next      = state;
    flush_left_next = flush_left;
    s_tready        = 1'b0;
    ctl             = '0;
    load_rem        = 1'b0;
    unique case (state)
      crcld_pkg::ST_RUN: begin
        s_tready = adv;
        if (s_tvalid && adv) begin
          ctl.step   = 1'b1;
          ctl.bit_in = s_tdata[0];
          if (s_tlast) begin
            state_next      = crcld_pkg::ST_FLUSH;
            flush_left_next = rb;
          end
        end
      end
      crcld_pkg::ST_FLUSH: begin
        // appended zeros
        if (adv) begin
          ctl.step = 1'b1;
          if (flush_left == CNT_W'(1)) begin
            state_next = crcld_pkg::ST_REM;
          end else begin
            flush_left_next = flush_left - CNT_W'(1);
          end
        end
      end
      crcld_pkg::ST_REM: begin
        if (adv) begin
          load_rem   = 1'b1;
          ctl.clear  = 1'b1;
          state_next = crcld_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = crcld_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.emit || load_rem) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      out_kind <= crcld_pkg::KIND_QUOT;
      out_q    <= stat.qbit;
      out_rem  <= '0;
      out_last <= 1'b0;
    end else if (load_rem) begin
      out_kind <= crcld_pkg::KIND_REM;
      out_q    <= 1'b0;
      out_rem  <= core_rem;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'({out_rem, out_q});
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  // last bit of a message always starts the zero flush
  `CRCLD_ASSERT_NEXT(a_last_flush, clk, rst, s_tvalid && s_tready && s_tlast, state == crcld_pkg::ST_FLUSH)
  // flush counter never idles at zero while flushing
  `CRCLD_ASSERT_NOW(a_flush_cnt, clk, rst, state == crcld_pkg::ST_FLUSH, flush_left != '0)
  // remainder results and only those close a run
  `CRCLD_ASSERT_NOW(a_kind_last, clk, rst, m_tvalid, m_tuser == m_tlast)
  // sending the remainder leaves the core cleared
  `CRCLD_ASSERT_NEXT(a_rem_clear, clk, rst, load_rem, core_rem == '0)

endmodule

@@ design/crcld_core.sv @@
// Division core: running remainder, window fill count, one bit per step.
// Depends on crcld_pkg.
module crcld_core #(
  parameter int MAX_DIVISOR_BITS = 33,
  localparam int PR_W  = MAX_DIVISOR_BITS - 1,
  localparam int CNT_W = $clog2(MAX_DIVISOR_BITS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  crcld_pkg::step_ctl_t        ctl,
  input  logic [MAX_DIVISOR_BITS-1:0] pattern,
  input  logic [CNT_W-1:0]            rb,       // divisor length minus one
  output crcld_pkg::step_stat_t       stat,
  output logic [PR_W-1:0]             remainder
);

  logic [PR_W-1:0]             pr;
  logic [PR_W-1:0]             pr_next;
  logic [CNT_W-1:0]            bits_seen;
  logic [MAX_DIVISOR_BITS-1:0] win;
  logic [MAX_DIVISOR_BITS-1:0] win_x;
  logic                        full;
  logic                        top;

  always_comb begin
    win   = {pr, ctl.bit_in};
    full  = (bits_seen >= rb);
    top   = win[rb];
    win_x = (full && top) ? (win ^ pattern) : win;
    // keep only the low rb bits: the top bit is dropped every step
    for (int i = 0; i < PR_W; i++) begin
      pr_next[i] = (i < int'(rb)) ? win_x[i] : 1'b0;
    end
    stat.emit = ctl.step && full;
    stat.qbit = top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr        <= '0;
      bits_seen <= '0;
    end else if (ctl.clear) begin
      pr        <= '0;
      bits_seen <= '0;
    end else if (ctl.step) begin
      pr <= pr_next;
      if (!full) begin
        bits_seen <= bits_seen + CNT_W'(1);
      end
    end
  end

  assign remainder = pr;

endmodule
